### design/grid_maze_dfs_path_finder_core_assert.svh
// assertion macros for the grid maze dfs path finder
// used by the controller and the top level
`ifndef GRID_MAZE_DFS_PATH_FINDER_CORE_ASSERT_SVH
`define GRID_MAZE_DFS_PATH_FINDER_CORE_ASSERT_SVH

// implication checked every clock outside reset
`define GM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define GM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/gmdfs_pkg.sv
// shared types and constants for the grid maze dfs path finder
// no dependencies
package gmdfs_pkg;

  localparam logic [7:0] ChOpen  = 8'h30;
  localparam logic [7:0] ChPath  = 8'h31;
  localparam logic [7:0] ChStart = 8'h53;
  localparam logic [7:0] ChEnd   = 8'h45;

  localparam logic [1:0] MkFree = 2'd0;
  localparam logic [1:0] MkSeen = 2'd1;
  localparam logic [1:0] MkDead = 2'd2;
  localparam logic [1:0] MkPath = 2'd3;

  localparam logic [0:0] CmdLoad = 1'b0;
  localparam logic [0:0] CmdRead = 1'b1;

  // datapath operations selected by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,      // write cell store, advance counter
    OP_CLR,       // clear one mark entry per cycle
    OP_START,     // push start cell
    OP_RD_NB,     // issue memory reads for current neighbour
    OP_TRY_NB,    // evaluate neighbour, push or step direction
    OP_POP,       // mark dead and pop
    OP_POP_RD,    // fetch new top of stack
    OP_POP_WB,    // take new current cell
    OP_MARK_RD,   // read stack entry for path marking
    OP_MARK_WR,   // mark path entry
    OP_RD_ISSUE,  // read route cell memories
    OP_RD_DONE    // route cell consumed
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic       ends_ok;     // start and end both seen
    logic       load_last;   // counter at last cell
    logic       clr_done;    // mark clear sweep at last entry
    logic       at_end;      // current cell is end
    logic       nb_push;     // evaluated neighbour is inside, open and unmarked
    logic       nb_last;     // last direction tried
    logic       stack_one;   // stack holds one entry
    logic       mark_last;   // path marking at last entry
    logic       read_last;   // read counter at last cell
  } dp_stat_t;

endpackage

### design/gmdfs_ctrl.sv
// controller state machine for the grid maze dfs path finder
// depends on gmdfs_pkg and the assertion macro header
`include "grid_maze_dfs_path_finder_core_assert.svh"
module gmdfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               in_valid_i,
  input  logic [0:0]         command_i,
  input  logic               out_free_i,
  input  gmdfs_pkg::dp_stat_t stat_i,
  output gmdfs_pkg::dp_cmd_t cmd_o,
  output logic               in_ready_o,
  output logic               stat_push_o,
  output logic               found_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_START, S_RD_NB, S_TRY_NB, S_POP, S_POP_RD, S_POP_WB,
    S_MARK_RD, S_MARK_WR, S_STATUS, S_READ, S_READ_WAIT
  } state_e;

  state_e state_q;
  logic   found_q;
  logic   accept;

  assign found_o = found_q;

  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD:  in_ready_o = 1'b1;
      S_READ:  in_ready_o = out_free_i;
      default: in_ready_o = 1'b0;
    endcase
  end
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.op    = gmdfs_pkg::OP_IDLE;
    stat_push_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (accept && command_i == gmdfs_pkg::CmdLoad) cmd_o.op = gmdfs_pkg::OP_LOAD;
      end
      S_CLR:     cmd_o.op = gmdfs_pkg::OP_CLR;
      S_START:   cmd_o.op = gmdfs_pkg::OP_START;
      S_RD_NB:   cmd_o.op = gmdfs_pkg::OP_RD_NB;
      S_TRY_NB:  cmd_o.op = gmdfs_pkg::OP_TRY_NB;
      S_POP:     cmd_o.op = gmdfs_pkg::OP_POP;
      S_POP_RD:  cmd_o.op = gmdfs_pkg::OP_POP_RD;
      S_POP_WB:  cmd_o.op = gmdfs_pkg::OP_POP_WB;
      S_MARK_RD: cmd_o.op = gmdfs_pkg::OP_MARK_RD;
      S_MARK_WR: cmd_o.op = gmdfs_pkg::OP_MARK_WR;
      S_STATUS:  stat_push_o = out_free_i;
      S_READ: begin
        if (accept && command_i == gmdfs_pkg::CmdRead) cmd_o.op = gmdfs_pkg::OP_RD_ISSUE;
      end
      S_READ_WAIT: cmd_o.op = gmdfs_pkg::OP_RD_DONE;
      default: cmd_o.op = gmdfs_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      found_q <= 1'b0;
    end else if (cfg_we_i) begin
      state_q <= S_LOAD;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (accept && command_i == gmdfs_pkg::CmdLoad && stat_i.load_last) begin
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          if (stat_i.clr_done) begin
            if (stat_i.ends_ok) state_q <= S_START;
            else state_q <= S_STATUS;
          end
        end
        S_START: state_q <= S_RD_NB;
        S_RD_NB: begin
          if (stat_i.at_end) begin
            found_q <= 1'b1;
            state_q <= S_MARK_RD;
          end else begin
            state_q <= S_TRY_NB;
          end
        end
        S_TRY_NB: begin
          if (stat_i.nb_push) state_q <= S_RD_NB;
          else if (stat_i.nb_last) state_q <= S_POP;
          else state_q <= S_RD_NB;
        end
        S_POP: begin
          if (stat_i.stack_one) state_q <= S_STATUS;
          else state_q <= S_POP_RD;
        end
        S_POP_RD:  state_q <= S_POP_WB;
        S_POP_WB:  state_q <= S_RD_NB;
        S_MARK_RD: state_q <= S_MARK_WR;
        S_MARK_WR: begin
          if (stat_i.mark_last) state_q <= S_STATUS;
          else state_q <= S_MARK_RD;
        end
        S_STATUS: begin
          if (out_free_i) state_q <= S_READ;
        end
        S_READ: begin
          if (accept && command_i == gmdfs_pkg::CmdRead) state_q <= S_READ_WAIT;
        end
        S_READ_WAIT: begin
          if (stat_i.read_last) begin
            state_q <= S_LOAD;
            found_q <= 1'b0;
          end else begin
            state_q <= S_READ;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `GM_ASSERT_IMP(a_ready_phase, clk_i, rst_ni, in_ready_o,
    state_q == S_LOAD || state_q == S_READ)
  `GM_ASSERT_NXT(a_status_then_read, clk_i, rst_ni, stat_push_o && !cfg_we_i,
    state_q == S_READ)
  `GM_ASSERT_IMP(a_found_walk, clk_i, rst_ni, state_q == S_MARK_RD, found_q)

endmodule

### design/gmdfs_dp.sv
// datapath for the grid maze dfs path finder: cell, mark and stack memories
// depends on gmdfs_pkg
module gmdfs_dp #(
  parameter int unsigned MaxDim = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic                cfg_valid_idx_i,
  input  logic [6:0]          cfg_data_i,
  input  gmdfs_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]          cell_char_i,
  input  logic                found_i,
  output gmdfs_pkg::dp_stat_t stat_o,
  output logic [7:0]          route_char_o,
  output logic                last_o
);

  localparam int unsigned Cells    = MaxDim * MaxDim;
  localparam int unsigned AW       = $clog2(Cells);
  localparam int unsigned DW       = $clog2(MaxDim + 1);
  localparam int unsigned CW       = AW + 1;
  // registers come out of reset at 64, saturated to MaxDim
  localparam int unsigned ResetDim = (MaxDim < 64) ? MaxDim : 64;

  logic [7:0]  cell_mem [Cells];
  logic [1:0]  mark_mem [Cells];
  logic [AW-1:0] stack_mem [Cells];

  logic [DW-1:0] width_q, height_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] cnt_q;        // load/read/clear/mark counter
  logic [CW-1:0] sp_q;         // stack count
  logic [AW-1:0] cur_q, start_q, end_q;
  logic [DW-1:0] row_q, col_q; // coordinates of cur_q
  logic [1:0]    ends_q;
  logic [1:0]    dir_q;
  logic [AW-1:0] nb_q;
  logic          nb_ok_q;
  logic [7:0]    cell_rd_q;
  logic [1:0]    mark_rd_q;
  logic [AW-1:0] stack_rd_q;
  logic [AW-1:0] rd_idx_q;

  logic [DW-1:0] dim_sat;
  logic [CW-1:0] nb_wide;
  logic          nb_in;
  logic [DW-1:0] nb_row, nb_col;

  // raster coordinates tracked along the load, and probe coordinates
  logic [DW-1:0] rl_row_q, rl_col_q, srow_q, scol_q, nb_row_q, nb_col_q;
  logic [DW-1:0] pop_row, pop_col;
  logic [2*DW-1:0] coord_mem [Cells];
  logic [2*DW-1:0] coord_rd_q;

  // saturate incoming dimension to 1..MaxDim
  always_comb begin
    if (cfg_data_i == 7'd0) dim_sat = DW'(1);
    else if (32'(cfg_data_i) > MaxDim) dim_sat = DW'(MaxDim);
    else dim_sat = DW'(cfg_data_i);
  end

  // neighbour for current direction: right, down, left, up
  always_comb begin
    nb_in  = 1'b0;
    nb_row = row_q;
    nb_col = col_q;
    case (dir_q)
      2'd0: begin
        nb_in  = (col_q + DW'(1)) < width_q;
        nb_col = col_q + DW'(1);
      end
      2'd1: begin
        nb_in  = (row_q + DW'(1)) < height_q;
        nb_row = row_q + DW'(1);
      end
      2'd2: begin
        nb_in  = col_q != '0;
        nb_col = col_q - DW'(1);
      end
      default: begin
        nb_in  = row_q != '0;
        nb_row = row_q - DW'(1);
      end
    endcase
    case (dir_q)
      2'd0:    nb_wide = CW'(cur_q) + CW'(1);
      2'd1:    nb_wide = CW'(cur_q) + CW'(width_q);
      2'd2:    nb_wide = CW'(cur_q) - CW'(1);
      default: nb_wide = CW'(cur_q) - CW'(width_q);
    endcase
  end

  assign stat_o.ends_ok   = ends_q == 2'b11;
  assign stat_o.load_last = cnt_q + CW'(1) == total_q;
  assign stat_o.clr_done  = cnt_q == CW'(Cells - 1);
  assign stat_o.at_end    = cur_q == end_q;
  assign stat_o.nb_push   = nb_ok_q && cell_rd_q == gmdfs_pkg::ChOpen
                            && mark_rd_q == gmdfs_pkg::MkFree;
  assign stat_o.nb_last   = dir_q == 2'd3;
  assign stat_o.stack_one = sp_q == CW'(1);
  assign stat_o.mark_last = cnt_q + CW'(1) == sp_q;
  assign stat_o.read_last = CW'(rd_idx_q) + CW'(1) == total_q;

  // route character from registered reads
  always_comb begin
    route_char_o = cell_rd_q;
    if (found_i && mark_rd_q == gmdfs_pkg::MkPath) route_char_o = gmdfs_pkg::ChPath;
    if (ends_q[0] && rd_idx_q == start_q) route_char_o = gmdfs_pkg::ChStart;
    if (ends_q[1] && rd_idx_q == end_q) route_char_o = gmdfs_pkg::ChEnd;
  end
  assign last_o = stat_o.read_last;

  // memories
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gmdfs_pkg::OP_LOAD:
        cell_mem[cnt_q[AW-1:0]] <= (cell_char_i == gmdfs_pkg::ChEnd)
                                   ? gmdfs_pkg::ChOpen : cell_char_i;
      gmdfs_pkg::OP_CLR: mark_mem[cnt_q[AW-1:0]] <= gmdfs_pkg::MkFree;
      gmdfs_pkg::OP_START: begin
        mark_mem[start_q] <= gmdfs_pkg::MkSeen;
        stack_mem[0]      <= start_q;
      end
      gmdfs_pkg::OP_RD_NB: begin
        cell_rd_q <= cell_mem[nb_wide[AW-1:0]];
        mark_rd_q <= mark_mem[nb_wide[AW-1:0]];
      end
      gmdfs_pkg::OP_TRY_NB: begin
        if (stat_o.nb_push) begin
          mark_mem[nb_q]               <= gmdfs_pkg::MkSeen;
          stack_mem[sp_q[AW-1:0]]      <= nb_q;
        end
      end
      gmdfs_pkg::OP_POP: mark_mem[cur_q] <= gmdfs_pkg::MkDead;
      gmdfs_pkg::OP_POP_RD: stack_rd_q <= stack_mem[sp_q[AW-1:0] - AW'(1)];
      gmdfs_pkg::OP_MARK_RD: stack_rd_q <= stack_mem[cnt_q[AW-1:0]];
      gmdfs_pkg::OP_MARK_WR: mark_mem[stack_rd_q] <= gmdfs_pkg::MkPath;
      gmdfs_pkg::OP_RD_ISSUE: begin
        cell_rd_q <= cell_mem[cnt_q[AW-1:0]];
        mark_rd_q <= mark_mem[cnt_q[AW-1:0]];
      end
      default: ;
    endcase
  end

  // payload of the neighbour probe
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gmdfs_pkg::OP_RD_NB) begin
      nb_q    <= nb_wide[AW-1:0];
      nb_ok_q <= nb_in;
    end
    if (cmd_i.op == gmdfs_pkg::OP_RD_ISSUE) rd_idx_q <= cnt_q[AW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(ResetDim);
      height_q <= DW'(ResetDim);
      total_q  <= CW'(ResetDim * ResetDim);
      cnt_q    <= '0;
      sp_q     <= '0;
      cur_q    <= '0;
      start_q  <= '0;
      end_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      ends_q   <= '0;
      dir_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_valid_idx_i) begin
        if (cfg_index_i == 1'b0) begin
          width_q <= dim_sat;
          total_q <= CW'(dim_sat) * CW'(height_q);
        end else begin
          height_q <= dim_sat;
          total_q  <= CW'(width_q) * CW'(dim_sat);
        end
        cnt_q  <= '0;
        ends_q <= '0;
        start_q <= '0;
        end_q   <= '0;
      end
    end else begin
      case (cmd_i.op)
        gmdfs_pkg::OP_LOAD: begin
          if (cell_char_i == gmdfs_pkg::ChStart) begin
            start_q   <= cnt_q[AW-1:0];
            ends_q[0] <= 1'b1;
          end else if (cell_char_i == gmdfs_pkg::ChEnd) begin
            end_q     <= cnt_q[AW-1:0];
            ends_q[1] <= 1'b1;
          end
          if (stat_o.load_last) cnt_q <= '0;
          else cnt_q <= cnt_q + CW'(1);
        end
        gmdfs_pkg::OP_CLR: begin
          if (stat_o.clr_done) cnt_q <= '0;
          else cnt_q <= cnt_q + CW'(1);
          sp_q  <= '0;
        end
        gmdfs_pkg::OP_START: begin
          cnt_q <= '0;
          cur_q <= start_q;
          row_q <= srow_q;
          col_q <= scol_q;
          sp_q  <= CW'(1);
          dir_q <= '0;
        end
        gmdfs_pkg::OP_TRY_NB: begin
          if (stat_o.nb_push) begin
            cur_q <= nb_q;
            row_q <= nb_row_q;
            col_q <= nb_col_q;
            sp_q  <= sp_q + CW'(1);
            dir_q <= '0;
          end else begin
            dir_q <= dir_q + 2'd1;
          end
        end
        gmdfs_pkg::OP_POP: sp_q <= sp_q - CW'(1);
        gmdfs_pkg::OP_POP_WB: begin
          cur_q <= stack_rd_q;
          row_q <= pop_row;
          col_q <= pop_col;
          dir_q <= '0;
        end
        gmdfs_pkg::OP_MARK_WR: begin
          if (stat_o.mark_last) cnt_q <= '0;
          else cnt_q <= cnt_q + CW'(1);
        end
        gmdfs_pkg::OP_RD_DONE: begin
          if (stat_o.read_last) begin
            cnt_q  <= '0;
            ends_q <= '0;
            start_q <= '0;
            end_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign pop_row = coord_rd_q[2*DW-1:DW];
  assign pop_col = coord_rd_q[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rl_row_q <= '0;
      rl_col_q <= '0;
      srow_q   <= '0;
      scol_q   <= '0;
    end else if (cfg_we_i) begin
      rl_row_q <= '0;
      rl_col_q <= '0;
    end else if (cmd_i.op == gmdfs_pkg::OP_LOAD) begin
      if (cell_char_i == gmdfs_pkg::ChStart) begin
        srow_q <= rl_row_q;
        scol_q <= rl_col_q;
      end
      if (stat_o.load_last) begin
        rl_row_q <= '0;
        rl_col_q <= '0;
      end else if (rl_col_q + DW'(1) == width_q) begin
        rl_col_q <= '0;
        rl_row_q <= rl_row_q + DW'(1);
      end else begin
        rl_col_q <= rl_col_q + DW'(1);
      end
    end
  end

  // coordinates stored alongside each stack entry for pops
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gmdfs_pkg::OP_RD_NB) begin
      nb_row_q <= nb_row;
      nb_col_q <= nb_col;
    end
    if (cmd_i.op == gmdfs_pkg::OP_START) coord_mem[0] <= {srow_q, scol_q};
    if (cmd_i.op == gmdfs_pkg::OP_TRY_NB && stat_o.nb_push)
      coord_mem[sp_q[AW-1:0]] <= {nb_row_q, nb_col_q};
    if (cmd_i.op == gmdfs_pkg::OP_POP_RD)
      coord_rd_q <= coord_mem[sp_q[AW-1:0] - AW'(1)];
  end

endmodule

### design/grid_maze_dfs_path_finder_core.sv
// top level of the grid maze dfs path finder: controller, datapath, output register
// depends on gmdfs_pkg, gmdfs_ctrl, gmdfs_dp and the assertion macro header
//
// loads and route reads move one cell per transaction; after issue a read holds
// input through memory read and output register, so reads do not overlap; loads
// at one per cycle. after the last load the block stops taking input: a clear of
// all MAX_DIM*MAX_DIM marks, then, with both ends seen, start push and walk, read
// and try per probed direction and pop, stack read and write-back per pop (one
// port per memory), then, if the end is found, path marking, a read and write per
// stack entry, then one status transaction. a config write to index 0 or 1
// restarts loading. the output register lets a result wait while the next load is
// taken. a command for the wrong phase is consumed with no result.
`include "grid_maze_dfs_path_finder_core_assert.svh"
module grid_maze_dfs_path_finder_core #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [0:0] command_i,
  input  logic [7:0] cell_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [0:0] result_kind_o,
  output logic [7:0] route_char_o,
  output logic [0:0] path_found_o,
  output logic [0:0] last_cell_o
);

  gmdfs_pkg::dp_cmd_t  cmd;
  gmdfs_pkg::dp_stat_t stat;
  logic       stat_push, found, out_free, cfg_hit;
  logic [7:0] dp_char;
  logic       dp_last;
  logic       out_valid_q;

  // only register indexes 0 and 1 take effect
  assign cfg_hit  = cfg_we_i && !cfg_index_i[1];
  assign out_free = !out_valid_q || out_ready_i;

  gmdfs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .cfg_we_i   (cfg_hit),
    .in_valid_i, .command_i,
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o,
    .stat_push_o(stat_push),
    .found_o    (found)
  );

  gmdfs_dp #(.MaxDim(MAX_DIM)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i       (cfg_hit),
    .cfg_index_i    (cfg_index_i[0]),
    .cfg_valid_idx_i(1'b1),
    .cfg_data_i,
    .cmd_i          (cmd),
    .cell_char_i,
    .found_i        (found),
    .stat_o         (stat),
    .route_char_o   (dp_char),
    .last_o         (dp_last)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat_push || cmd.op == gmdfs_pkg::OP_RD_DONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_push) begin
      result_kind_o <= 1'b0;
      route_char_o  <= 8'd0;
      path_found_o  <= found;
      last_cell_o   <= 1'b0;
    end else if (cmd.op == gmdfs_pkg::OP_RD_DONE) begin
      result_kind_o <= 1'b1;
      route_char_o  <= dp_char;
      path_found_o  <= found;
      last_cell_o   <= dp_last;
    end
  end
  assign out_valid_o = out_valid_q;

  `GM_ASSERT_NXT(a_push_valid, clk_i, rst_ni, stat_push, out_valid_o)
  `GM_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, stat_push, out_free)
  `GM_ASSERT_IMP(a_read_kind, clk_i, rst_ni, out_valid_o && last_cell_o, result_kind_o)

endmodule

### bench/tb.sv
// testbench for grid_maze_dfs_path_finder_core: loads mazes, checks solve status and route
// depends on gmdfs_pkg and the rtl top level; self-contained predictor, no files read
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Dim   = 64;
  localparam int Cells = Dim * Dim;

  // dut side signals; the inputs are known from time zero
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [0:0] command_i = gmdfs_pkg::CmdLoad;
  logic [7:0] cell_char_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [0:0] result_kind_o;
  logic [7:0] route_char_o;
  logic [0:0] path_found_o;
  logic [0:0] last_cell_o;

  grid_maze_dfs_path_finder_core #(.MAX_DIM(Dim)) u_top (.*);

  always #2 clk_i = ~clk_i;

  // one expected result transaction
  typedef struct {
    logic [0:0] kind;
    logic [7:0] ch;
    logic [0:0] found;
    logic [0:0] last;
  } route_result_t;

  route_result_t pending_results[$];

  // shadow of the solver state
  logic [7:0] maze_cells[Cells];
  logic [1:0] maze_marks[Cells];
  int         dfs_stack[Cells];
  int         dfs_depth, cell_pos, start_pos, end_pos, grid_w, grid_h;
  logic [1:0] ends_seen;
  logic       solved, reading;

  int  n_items, n_results, n_errors, n_mazes, n_solved;
  bit  no_gaps, no_stalls;

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > Dim) return Dim;
    return v;
  endfunction

  function automatic void restart_load();
    cell_pos = 0; dfs_depth = 0; start_pos = 0; end_pos = 0;
    ends_seen = '0; solved = 1'b0; reading = 1'b0;
  endfunction

  function automatic bit free_cell(int i);
    return maze_cells[i] == gmdfs_pkg::ChOpen && maze_marks[i] == gmdfs_pkg::MkFree;
  endfunction

  function automatic void push_cell(int i);
    maze_marks[i] = gmdfs_pkg::MkSeen;
    dfs_stack[dfs_depth++] = i;
  endfunction

  // depth-first walk: right, down, left, up
  function automatic void solve_maze();
    int cur, r, c;
    foreach (maze_marks[i]) maze_marks[i] = gmdfs_pkg::MkFree;
    dfs_depth = 0;
    solved = 1'b0;
    if (ends_seen != 2'b11) return;
    cur = start_pos;
    push_cell(cur);
    while (cur != end_pos) begin
      r = cur / grid_w;
      c = cur % grid_w;
      if (c + 1 < grid_w && free_cell(cur + 1)) begin
        cur = cur + 1; push_cell(cur);
      end else if (r + 1 < grid_h && free_cell(cur + grid_w)) begin
        cur = cur + grid_w; push_cell(cur);
      end else if (c > 0 && free_cell(cur - 1)) begin
        cur = cur - 1; push_cell(cur);
      end else if (r > 0 && free_cell(cur - grid_w)) begin
        cur = cur - grid_w; push_cell(cur);
      end else begin
        maze_marks[cur] = gmdfs_pkg::MkDead;
        dfs_depth--;
        if (dfs_depth == 0) return;
        cur = dfs_stack[dfs_depth - 1];
      end
    end
    solved = 1'b1;
    for (int i = 0; i < dfs_depth; i++) maze_marks[dfs_stack[i]] = gmdfs_pkg::MkPath;
  endfunction

  // expected results of one accepted transaction
  function automatic void predict_route(logic [0:0] cmd, logic [7:0] ch);
    route_result_t res;
    int total;
    total = grid_w * grid_h;
    if (cmd == gmdfs_pkg::CmdLoad) begin
      if (reading) return;
      if (ch == gmdfs_pkg::ChStart) begin
        start_pos = cell_pos; ends_seen[0] = 1'b1;
      end else if (ch == gmdfs_pkg::ChEnd) begin
        end_pos = cell_pos; ends_seen[1] = 1'b1; ch = gmdfs_pkg::ChOpen;
      end
      maze_cells[cell_pos] = ch;
      cell_pos++;
      if (cell_pos < total) return;
      solve_maze();
      reading = 1'b1;
      cell_pos = 0;
      res = '{kind: 1'b0, ch: 8'h00, found: solved, last: 1'b0};
      n_mazes++;
      if (solved) n_solved++;
      pending_results.push_back(res);
    end else begin
      if (!reading) return;
      res.ch = maze_cells[cell_pos];
      if (solved && maze_marks[cell_pos] == gmdfs_pkg::MkPath) res.ch = gmdfs_pkg::ChPath;
      if (ends_seen[0] && cell_pos == start_pos) res.ch = gmdfs_pkg::ChStart;
      if (ends_seen[1] && cell_pos == end_pos) res.ch = gmdfs_pkg::ChEnd;
      res.kind = 1'b1;
      res.found = solved;
      res.last = (cell_pos + 1 == total);
      pending_results.push_back(res);
      if (res.last) restart_load();
      else cell_pos++;
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // sink side: random stalls, occasionally long
  int stall_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_stalls && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker: every output transaction against the oldest expectation
  always @(posedge clk_i) begin
    route_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d char %h", result_kind_o, route_char_o);
        n_errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (result_kind_o !== exp_res.kind) begin
          $error("result_kind expected %0d actual %0d", exp_res.kind, result_kind_o);
          n_errors++;
        end
        if (route_char_o !== exp_res.ch) begin
          $error("route_char expected %h actual %h", exp_res.ch, route_char_o);
          n_errors++;
        end
        if (path_found_o !== exp_res.found) begin
          $error("path_found expected %0d actual %0d", exp_res.found, path_found_o);
          n_errors++;
        end
        if (last_cell_o !== exp_res.last) begin
          $error("last_cell expected %0d actual %0d", exp_res.last, last_cell_o);
          n_errors++;
        end
      end
    end
  end

  // one input transaction; valid stays high when the next one follows at once
  task automatic send_cell(logic [0:0] cmd, logic [7:0] ch);
    int gap;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    cell_char_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    predict_route(cmd, ch);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait for all expected results, then for the block to settle
  task automatic drain();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_errors++;
      pending_results.delete();
    end
    repeat (16) @(posedge clk_i);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == 2'd0) begin
      grid_w = clamp_dim(int'(data));
      restart_load();
    end else if (idx == 2'd1) begin
      grid_h = clamp_dim(int'(data));
      restart_load();
    end
    @(posedge clk_i);
  endtask

  task automatic set_grid(int w, int h);
    write_reg(2'd0, 7'(w));
    write_reg(2'd1, 7'(h));
  endtask

  function automatic logic [7:0] wall_char();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == gmdfs_pkg::ChOpen || c == gmdfs_pkg::ChStart || c == gmdfs_pkg::ChEnd)
      c = 8'h23;
    return c;
  endfunction

  // full maze: all loads, then every route cell; noise puts wrong-phase commands in
  task automatic play_maze(logic [7:0] m[$], int noise_pct);
    foreach (m[i]) begin
      if ($urandom_range(0, 99) < noise_pct) send_cell(gmdfs_pkg::CmdRead, 8'($urandom));
      send_cell(gmdfs_pkg::CmdLoad, m[i]);
    end
    for (int i = 0; i < grid_w * grid_h; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_cell(gmdfs_pkg::CmdLoad, 8'($urandom));
      send_cell(gmdfs_pkg::CmdRead, 8'($urandom));
    end
  endtask

  // random maze; style picks normal, missing start, missing end or duplicate ends
  function automatic void build_maze(ref logic [7:0] m[$], input int open_pct, int style);
    int total, s, e;
    total = grid_w * grid_h;
    m.delete();
    for (int i = 0; i < total; i++)
      m.push_back(($urandom_range(0, 99) < open_pct) ? gmdfs_pkg::ChOpen : wall_char());
    s = $urandom_range(0, total - 1);
    e = $urandom_range(0, total - 1);
    if (style == 3) begin
      m[$urandom_range(0, total - 1)] = gmdfs_pkg::ChStart;
      m[$urandom_range(0, total - 1)] = gmdfs_pkg::ChEnd;
    end
    if (style != 1) m[s] = gmdfs_pkg::ChStart;
    if (style != 2 && e != s) m[e] = gmdfs_pkg::ChEnd;
  endfunction

  // registers at their reset value: a partial load of the largest grid gives no status
  task automatic test_reset_size();
    logic [7:0] m[$];
    no_gaps = 1'b1;
    build_maze(m, 80, 0);
    for (int i = 0; i < 300; i++) send_cell(gmdfs_pkg::CmdLoad, m[i]);
    no_gaps = 1'b0;
    set_grid(Dim, Dim);
  endtask

  // small hand-made mazes and register extremes
  task automatic test_directed();
    logic [7:0] m[$];
    set_grid(0, 0);                 // zero counts as one
    m = {gmdfs_pkg::ChStart};       // no end: no walk
    play_maze(m, 0);
    write_reg(2'd2, 7'd5);          // index beyond the list, ignored
    set_grid(2, 1);
    m = {gmdfs_pkg::ChStart, gmdfs_pkg::ChEnd};
    play_maze(m, 0);
    set_grid(1, 2);
    m = {gmdfs_pkg::ChEnd, gmdfs_pkg::ChStart};
    play_maze(m, 0);
    // right neighbor of S wraps to E, which must count as outside the grid
    set_grid(2, 2);
    m = {gmdfs_pkg::ChOpen, gmdfs_pkg::ChStart, gmdfs_pkg::ChEnd, 8'hff};
    play_maze(m, 0);
    // walled-in start: stack runs empty
    set_grid(3, 1);
    m = {gmdfs_pkg::ChStart, 8'h23, gmdfs_pkg::ChEnd};
    play_maze(m, 0);
    // two starts, two ends: earlier end reads back as open
    set_grid(3, 2);
    m = {gmdfs_pkg::ChStart, 8'h00, gmdfs_pkg::ChEnd, 8'h7f,
         gmdfs_pkg::ChStart, gmdfs_pkg::ChEnd};
    play_maze(m, 30);
    set_grid(127, 1);               // saturates to the maximum width
    build_maze(m, 90, 0);
    play_maze(m, 0);
    set_grid(1, 127);
    build_maze(m, 90, 0);
    play_maze(m, 0);
    drain();
  endtask

  // random mazes of mostly small size, some aborted by a register write
  task automatic test_random();
    logic [7:0] m[$];
    int w, h, style, cut;
    while (n_items < 1200) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(20, 64); h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 8); h = $urandom_range(1, 8);
      end
      if (grid_w != w || grid_h != h || $urandom_range(0, 3) == 0) set_grid(w, h);
      no_gaps = ($urandom_range(0, 5) == 0);
      no_stalls = ($urandom_range(0, 5) == 0);
      style = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
      build_maze(m, $urandom_range(45, 90), style);
      if ($urandom_range(0, 14) == 0) begin
        cut = $urandom_range(0, m.size() - 1);
        for (int i = 0; i < cut; i++) send_cell(gmdfs_pkg::CmdLoad, m[i]);
        set_grid(w, h);
      end else begin
        play_maze(m, ($urandom_range(0, 3) == 0) ? 15 : 0);
      end
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    drain();
  endtask

  initial begin
    grid_w = Dim; grid_h = Dim;
    restart_load();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_directed();
    test_random();
    $display("%0d input transactions, %0d results, %0d mazes solved (%0d with a path)",
             n_items, n_results, n_mazes, n_solved);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
